// ===== hdl/jsu_pkg.sv =====
// Shared types, constants and a helper function for the JSON string unescaper.
package jsu_pkg;

  // Decoder phase
  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_STR  = 3'd1,
    PH_ESC  = 3'd2,
    PH_HEX  = 3'd3
  } phase_t;

  // Result status codes
  localparam logic [1:0] ST_BYTE   = 2'd0;
  localparam logic [1:0] ST_DONE   = 2'd1;
  localparam logic [1:0] ST_REJECT = 2'd2;

  // Character constants
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_CTRL_LIMIT = 8'h20;
  localparam logic [7:0] CH_LOW_B = 8'h62;
  localparam logic [7:0] CH_LOW_F = 8'h66;
  localparam logic [7:0] CH_LOW_N = 8'h6E;
  localparam logic [7:0] CH_LOW_R = 8'h72;
  localparam logic [7:0] CH_LOW_T = 8'h74;
  localparam logic [7:0] CH_LOW_U = 8'h75;

  // UTF-8 ranges and prefixes
  localparam logic [15:0] CP_ONE_MAX = 16'h007F;
  localparam logic [15:0] CP_TWO_MAX = 16'h07FF;
  localparam logic [15:0] CP_SURR_LO = 16'hD800;
  localparam logic [15:0] CP_SURR_HI = 16'hDFFF;
  localparam logic [7:0]  UTF_LEAD2  = 8'hC0;
  localparam logic [7:0]  UTF_LEAD3  = 8'hE0;
  localparam logic [7:0]  UTF_CONT   = 8'h80;

  localparam logic [15:0] CAP_RESET = 16'd96;

  // Results per input byte and output queue sizing
  localparam int MAX_RES   = 3;
  localparam int Q_DEPTH   = 8;
  localparam int Q_AW      = $clog2(Q_DEPTH);
  localparam int Q_CW      = $clog2(Q_DEPTH + 1);
  localparam int Q_ROOM    = Q_DEPTH - MAX_RES;

  // One result as produced by the decoder
  typedef struct packed {
    logic [7:0] data;
    logic [1:0] status;
  } res_t;

  // All results of one input byte
  typedef struct packed {
    logic [1:0]           num;
    res_t [MAX_RES-1:0]   ent;
  } res_bundle_t;

  // One queued result with its end-of-item flag
  typedef struct packed {
    logic [7:0] data;
    logic [1:0] status;
    logic       last;
  } q_entry_t;

  // Hex digit decode: bit 4 is the valid flag, bits 3:0 the digit
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

// ===== hdl/jsu_decode.sv =====
// Escape decoder: phase state, hex gathering, UTF-8 encoding and capacity check.
module jsu_decode import jsu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  logic [7:0]  in_byte,
  input  logic [15:0] cap,
  output res_bundle_t res
);

  phase_t      phase_r, phase_nxt;
  logic [15:0] acc_r, acc_nxt;
  logic [1:0]  seen_r, seen_nxt;
  logic [15:0] dc_r, dc_nxt;

  logic [1:0]  seq_n;
  logic [7:0]  seq_b [MAX_RES];
  logic        term;
  logic [1:0]  term_st;
  logic        ended;
  logic        dc_clear;
  logic [4:0]  hexv;
  logic [MAX_RES-1:0] fit;
  logic [1:0]  k;

  assign hexv = hex_nibble(in_byte);

  // Next state and results for the byte at the input register
  always_comb begin
    seq_n     = '0;
    for (int i = 0; i < MAX_RES; i++) begin
      seq_b[i] = '0;
    end
    term      = 1'b0;
    term_st   = ST_DONE;
    ended     = 1'b0;
    dc_clear  = 1'b0;
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    seen_nxt  = seen_r;

    case (phase_r)
      PH_IDLE: begin
        if (in_byte == CH_QUOTE && cap != '0) begin
          phase_nxt = PH_STR;
          dc_clear  = 1'b1;
        end else begin
          term    = 1'b1;
          term_st = ST_REJECT;
        end
      end
      PH_STR: begin
        if (in_byte == CH_QUOTE) begin
          term    = 1'b1;
          term_st = ST_DONE;
          ended   = 1'b1;
        end else if (in_byte < CH_CTRL_LIMIT) begin
          term    = 1'b1;
          term_st = ST_REJECT;
          ended   = 1'b1;
        end else if (in_byte == CH_BSLASH) begin
          phase_nxt = PH_ESC;
        end else begin
          seq_n    = 2'd1;
          seq_b[0] = in_byte;
        end
      end
      PH_ESC: begin
        phase_nxt = PH_STR;
        case (in_byte)
          CH_QUOTE, CH_BSLASH, CH_SLASH: begin
            seq_n    = 2'd1;
            seq_b[0] = in_byte;
          end
          CH_LOW_B: begin
            seq_n    = 2'd1;
            seq_b[0] = 8'h08;
          end
          CH_LOW_F: begin
            seq_n    = 2'd1;
            seq_b[0] = 8'h0C;
          end
          CH_LOW_N: begin
            seq_n    = 2'd1;
            seq_b[0] = 8'h0A;
          end
          CH_LOW_R: begin
            seq_n    = 2'd1;
            seq_b[0] = 8'h0D;
          end
          CH_LOW_T: begin
            seq_n    = 2'd1;
            seq_b[0] = 8'h09;
          end
          CH_LOW_U: begin
            phase_nxt = PH_HEX;
            acc_nxt   = '0;
            seen_nxt  = '0;
          end
          default: begin
            term    = 1'b1;
            term_st = ST_REJECT;
            ended   = 1'b1;
          end
        endcase
      end
      PH_HEX: begin
        if (!hexv[4]) begin
          term    = 1'b1;
          term_st = ST_REJECT;
          ended   = 1'b1;
        end else begin
          acc_nxt = {acc_r[11:0], hexv[3:0]};
          if (seen_r == 2'd3) begin
            seen_nxt  = '0;
            phase_nxt = PH_STR;
            // Encode the gathered code point as UTF-8; a surrogate code point becomes '?'
            if (acc_nxt <= CP_ONE_MAX) begin
              seq_n    = 2'd1;
              seq_b[0] = acc_nxt[7:0];
            end else if (acc_nxt <= CP_TWO_MAX) begin
              seq_n    = 2'd2;
              seq_b[0] = UTF_LEAD2 | {3'b000, acc_nxt[10:6]};
              seq_b[1] = UTF_CONT | {2'b00, acc_nxt[5:0]};
            end else if (acc_nxt >= CP_SURR_LO && acc_nxt <= CP_SURR_HI) begin
              seq_n    = 2'd1;
              seq_b[0] = CH_QMARK;
            end else begin
              seq_n    = 2'd3;
              seq_b[0] = UTF_LEAD3 | {4'b0000, acc_nxt[15:12]};
              seq_b[1] = UTF_CONT | {2'b00, acc_nxt[11:6]};
              seq_b[2] = UTF_CONT | {2'b00, acc_nxt[5:0]};
            end
          end else begin
            seen_nxt = seen_r + 2'd1;
          end
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase

    // Capacity check: byte i of the sequence fits while count + i + 1 < capacity
    k = '0;
    for (int i = 0; i < MAX_RES; i++) begin
      fit[i] = ({1'b0, dc_r} + 17'(i + 1)) < {1'b0, cap};
      if (2'(i) < seq_n && fit[i]) begin
        k = k + 2'd1;
      end
    end
    if (k != seq_n) begin
      term    = 1'b1;
      term_st = ST_REJECT;
      ended   = 1'b1;
    end

    dc_nxt = dc_clear ? '0 : dc_r + 16'(k);

    if (ended) begin
      phase_nxt = PH_IDLE;
      acc_nxt   = '0;
      seen_nxt  = '0;
    end

    // Pack decoded bytes followed by the optional status result
    res.num = k + 2'(term);
    for (int i = 0; i < MAX_RES; i++) begin
      if (2'(i) < k) begin
        res.ent[i] = '{data: seq_b[i], status: ST_BYTE};
      end else begin
        res.ent[i] = '{data: 8'h00, status: term_st};
      end
    end
  end

  // Advance state when the byte is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      acc_r   <= '0;
      seen_r  <= '0;
      dc_r    <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      seen_r  <= seen_nxt;
      dc_r    <= dc_nxt;
    end
  end

endmodule

// ===== hdl/jsu_out_queue.sv =====
// Result queue: takes up to three results per cycle, hands out one per transfer.
module jsu_out_queue import jsu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        wr_en,
  input  res_bundle_t wr_res,
  output logic        room,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic [1:0]  out_status,
  output logic        out_last
);

  q_entry_t          q_r [Q_DEPTH];
  logic [Q_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_CW-1:0]   cnt_r, cnt_nxt;
  logic [1:0]        wr_n;
  logic              rd;

  assign wr_n      = wr_en ? wr_res.num : 2'd0;
  assign rd        = out_valid && out_ready;
  assign room      = cnt_r <= Q_CW'(Q_ROOM);
  assign out_valid = cnt_r != '0;
  assign out_byte   = q_r[rd_ptr_r].data;
  assign out_status = q_r[rd_ptr_r].status;
  assign out_last   = q_r[rd_ptr_r].last;

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + Q_AW'(wr_n);
    rd_ptr_nxt = rd_ptr_r + Q_AW'(rd);
    cnt_nxt    = cnt_r + Q_CW'(wr_n) - Q_CW'(rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store results, flagging the final one of the item
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RES; i++) begin
      if (2'(i) < wr_n) begin
        q_r[wr_ptr_r + Q_AW'(i)] <= '{data:   wr_res.ent[i].data,
                                      status: wr_res.ent[i].status,
                                      last:   (2'(i) == wr_n - 2'd1)};
      end
    end
  end

endmodule

// ===== hdl/json_string_unescape_top.sv =====
// JSON string unescaper top level: input register, decoder, result queue.
// Flow: a transferred byte is held in the input register, then decoded and
// written into the result queue once the queue has room for its results.
// Throughput: one input byte per cycle while the queue has room; results leave
// through a single output port at one per cycle while out_ready is high.
// Reset (rst_n low, synchronous): phase idle, counters cleared, queue empty,
// output capacity back to 96.
module json_string_unescape_top import jsu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic [1:0]  out_status,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_output_capacity
);

  logic        in_vld_r, in_vld_nxt;
  logic [7:0]  in_byte_r;
  logic [15:0] cap_r;
  logic        room;
  logic        step;
  res_bundle_t res;

  assign cfg_ready = 1'b1;
  assign step      = in_vld_r && room;
  assign in_ready  = !in_vld_r || room;

  // Hold the input byte until the queue has room for its results
  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_valid && in_ready) begin
      in_vld_nxt = 1'b1;
    end else if (step) begin
      in_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_byte;
    end
  end

  // Capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      cap_r <= cfg_output_capacity;
    end
  end

  jsu_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .in_byte (in_byte_r),
    .cap     (cap_r),
    .res     (res)
  );

  jsu_out_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr_en      (step),
    .wr_res     (res),
    .room       (room),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .out_status (out_status),
    .out_last   (out_last)
  );

endmodule
